FILE: hdl/etl_pkg.sv
`default_nettype none
package etl_pkg;

  localparam int POS_BITS = 32;
  localparam int BEGIN_BITS = 32;
  localparam int STOP_BITS = 33;
  localparam int FILE_BITS = 16;
  localparam int VALUE_BITS = 64;
  localparam int TOK_SLOTS = 3;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  // Register indexes (byte address is 4 times the index).
  localparam logic [CFG_ADDR_BITS-3:0] REG_FILE_ID = '0;

  localparam logic [VALUE_BITS-1:0] ACC_MAX = '1;
  localparam logic [VALUE_BITS-1:0] ACC_LIMIT = ACC_MAX / 64'd10;
  localparam logic [VALUE_BITS-1:0] ACC_LAST_DIGIT = ACC_MAX % 64'd10;

  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef logic [POS_BITS-1:0] pos_t;

  typedef enum logic [3:0] {
    KIND_PLUS    = 4'd0,
    KIND_MINUS   = 4'd1,
    KIND_STAR    = 4'd2,
    KIND_SLASH   = 4'd3,
    KIND_LPAREN  = 4'd4,
    KIND_RPAREN  = 4'd5,
    KIND_COMMA   = 4'd6,
    KIND_EQUAL   = 4'd7,
    KIND_LBRACE  = 4'd8,
    KIND_RBRACE  = 4'd9,
    KIND_NUMBER  = 4'd10,
    KIND_IDENT   = 4'd11,
    KIND_UNKNOWN = 4'd12,
    KIND_END     = 4'd13
  } kind_t;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_NUM   = 2'd1,
    MODE_IDENT = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       byte_valid;
    logic       end_of_source;
  } in_item_t;

  typedef struct packed {
    kind_t                  token_kind;
    logic [BEGIN_BITS-1:0]  span_begin;
    logic [STOP_BITS-1:0]   span_stop;
    logic [FILE_BITS-1:0]   span_file;
    logic [VALUE_BITS-1:0]  number_value;
    logic                   value_saturated;
    logic                   last_of_run;
  } token_t;

  typedef struct packed {
    logic       load;
    logic [1:0] count;
  } load_ctl_t;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } punct_t;

  function automatic punct_t punct_lookup(input logic [7:0] c);
    punct_t p;
    p.hit = 1'b1;
    p.kind = KIND_PLUS;
    case (c)
      CH_PLUS:   p.kind = KIND_PLUS;
      CH_MINUS:  p.kind = KIND_MINUS;
      CH_STAR:   p.kind = KIND_STAR;
      CH_SLASH:  p.kind = KIND_SLASH;
      CH_LPAREN: p.kind = KIND_LPAREN;
      CH_RPAREN: p.kind = KIND_RPAREN;
      CH_COMMA:  p.kind = KIND_COMMA;
      CH_EQUAL:  p.kind = KIND_EQUAL;
      CH_LBRACE: p.kind = KIND_LBRACE;
      CH_RBRACE: p.kind = KIND_RBRACE;
      default:   p.hit = 1'b0;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/etl_in_if.sv
`default_nettype none
interface etl_in_if;
  import etl_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

FILE: hdl/etl_out_if.sv
`default_nettype none
interface etl_out_if;
  import etl_pkg::*;
  logic   valid;
  logic   ready;
  token_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface
`default_nettype wire

FILE: hdl/expression_token_lexer.sv
// Path: a byte's tokens pass the input register and then the token buffer.
// Throughput: one byte per cycle while the token buffer is free; a byte that yields tokens
// holds the input until the three-slot token buffer, which has one output port, can take them.
// Reset: synchronous, active-low rst_n clears the scan state, file id and buffer count.
`default_nettype none
module expression_token_lexer (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  etl_in_if.sink                                    in_if,
  etl_out_if.source                                 out_if,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [etl_pkg::CFG_ADDR_BITS-1:0]    paddr,
  input  wire logic [etl_pkg::CFG_DATA_BITS-1:0]    pwdata,
  output logic      [etl_pkg::CFG_DATA_BITS-1:0]    prdata,
  output logic                                      pready
);
  import etl_pkg::*;

  logic [FILE_BITS-1:0] file_id;
  logic                 buf_free;
  load_ctl_t            load_ctl;
  token_t               toks [TOK_SLOTS];

  etl_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .file_id (file_id)
  );

  etl_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .file_id  (file_id),
    .buf_free (buf_free),
    .load_ctl (load_ctl),
    .toks     (toks)
  );

  etl_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load_ctl (load_ctl),
    .toks     (toks),
    .buf_free (buf_free),
    .out_if   (out_if)
  );
endmodule
`default_nettype wire

FILE: hdl/etl_cfg.sv
`default_nettype none
module etl_cfg (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [etl_pkg::CFG_ADDR_BITS-1:0]    paddr,
  input  wire logic [etl_pkg::CFG_DATA_BITS-1:0]    pwdata,
  output logic      [etl_pkg::CFG_DATA_BITS-1:0]    prdata,
  output logic                                      pready,
  output logic      [etl_pkg::FILE_BITS-1:0]        file_id
);
  import etl_pkg::*;

  logic [FILE_BITS-1:0] file_id_r;
  logic [FILE_BITS-1:0] file_id_nxt;
  logic                 sel_file;

  assign sel_file = (paddr[CFG_ADDR_BITS-1:2] == REG_FILE_ID);
  assign pready = 1'b1;

  always_comb begin
    file_id_nxt = file_id_r;
    if (psel && penable && pwrite && sel_file) begin
      file_id_nxt = pwdata[FILE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_id_r <= '0;
    end else begin
      file_id_r <= file_id_nxt;
    end
  end

  assign prdata = sel_file ? CFG_DATA_BITS'(file_id_r) : '0;
  assign file_id = file_id_r;
endmodule
`default_nettype wire

FILE: hdl/etl_scan.sv
`default_nettype none
module etl_scan (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  etl_in_if.sink                               in_if,
  input  wire logic [etl_pkg::FILE_BITS-1:0]   file_id,
  input  wire logic                            buf_free,
  output etl_pkg::load_ctl_t                   load_ctl,
  output etl_pkg::token_t                      toks [etl_pkg::TOK_SLOTS]
);
  import etl_pkg::*;

  logic      in_vld_r;
  in_item_t  in_item_r;
  mode_t     mode_r, mode_nxt;
  pos_t      run_start_r, run_start_nxt;
  pos_t      pos_r, pos_nxt;
  logic [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic      ovf_r, ovf_nxt;

  logic [7:0] c;
  logic       bv, eos;
  logic       is_dig, is_alpha, is_space;
  punct_t     pm;
  logic       cont, brk;
  mode_t      mode1;
  pos_t       start1, pos1;
  logic [VALUE_BITS-1:0] acc1, acc_step, dig_val;
  logic       ovf1, ovf_step;
  logic [1:0] n_tok;
  logic       proc;

  function automatic token_t mk_tok(input kind_t k, input pos_t b,
                                    input logic [STOP_BITS-1:0] s,
                                    input logic [VALUE_BITS-1:0] v, input logic sat,
                                    input logic [FILE_BITS-1:0] f);
    token_t t;
    t.token_kind = k;
    t.span_begin = BEGIN_BITS'(b);
    t.span_stop = s;
    t.span_file = f;
    t.number_value = v;
    t.value_saturated = sat;
    t.last_of_run = 1'b0;
    return t;
  endfunction

  function automatic logic [STOP_BITS-1:0] stop_after(input pos_t p);
    logic [POS_BITS:0] s;
    s = {1'b0, p} + (POS_BITS+1)'(1);
    return STOP_BITS'(s);
  endfunction

  assign c = in_item_r.char_byte;
  assign bv = in_item_r.byte_valid;
  assign eos = in_item_r.end_of_source;
  assign is_dig = (c >= 8'h30) && (c <= 8'h39);
  assign is_alpha = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  assign is_space = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  assign pm = punct_lookup(c);
  assign cont = bv && (((mode_r == MODE_NUM) && is_dig) ||
                       ((mode_r == MODE_IDENT) && (is_alpha || is_dig)));
  assign brk = bv && !cont;
  assign dig_val = VALUE_BITS'(c[3:0]);

  // Saturating value*10+digit; the product is built from two shifts.
  always_comb begin
    acc_step = acc_r;
    ovf_step = ovf_r;
    if (!ovf_r) begin
      if ((acc_r > ACC_LIMIT) || ((acc_r == ACC_LIMIT) && (dig_val > ACC_LAST_DIGIT))) begin
        acc_step = ACC_MAX;
        ovf_step = 1'b1;
      end else begin
        acc_step = (acc_r << 3) + (acc_r << 1) + dig_val;
      end
    end
  end

  // Run state after the byte, before any end-of-source flush.
  always_comb begin
    mode1 = mode_r;
    start1 = run_start_r;
    acc1 = acc_r;
    ovf1 = ovf_r;
    pos1 = pos_r;
    if (bv) begin
      pos1 = pos_r + POS_BITS'(1);
      if (cont) begin
        if (mode_r == MODE_NUM) begin
          acc1 = acc_step;
          ovf1 = ovf_step;
        end
      end else begin
        acc1 = '0;
        ovf1 = 1'b0;
        mode1 = MODE_NONE;
        if (!pm.hit && is_dig) begin
          mode1 = MODE_NUM;
          start1 = pos_r;
          acc1 = dig_val;
        end else if (!pm.hit && is_alpha) begin
          mode1 = MODE_IDENT;
          start1 = pos_r;
        end
      end
    end
  end

  always_comb begin
    mode_nxt = mode1;
    run_start_nxt = start1;
    pos_nxt = pos1;
    acc_nxt = acc1;
    ovf_nxt = ovf1;
    if (eos) begin
      mode_nxt = MODE_NONE;
      run_start_nxt = '0;
      pos_nxt = '0;
      acc_nxt = '0;
      ovf_nxt = 1'b0;
    end
  end

  // Token list in emission order: old run, single byte, run closed by end, end.
  always_comb begin
    token_t cand [4];
    logic   pres [4];
    n_tok = '0;
    for (int i = 0; i < TOK_SLOTS; i++) begin
      toks[i] = '0;
    end
    cand[0] = (mode_r == MODE_NUM) ?
              mk_tok(KIND_NUMBER, run_start_r, STOP_BITS'(pos_r), acc_r, ovf_r, file_id) :
              mk_tok(KIND_IDENT, run_start_r, STOP_BITS'(pos_r), '0, 1'b0, file_id);
    pres[0] = brk && (mode_r != MODE_NONE);
    cand[1] = mk_tok(pm.hit ? pm.kind : KIND_UNKNOWN, pos_r, stop_after(pos_r), '0, 1'b0,
                     file_id);
    pres[1] = brk && (pm.hit || (!is_dig && !is_alpha && !is_space));
    cand[2] = (mode1 == MODE_NUM) ?
              mk_tok(KIND_NUMBER, start1, STOP_BITS'(pos1), acc1, ovf1, file_id) :
              mk_tok(KIND_IDENT, start1, STOP_BITS'(pos1), '0, 1'b0, file_id);
    pres[2] = eos && (mode1 != MODE_NONE);
    cand[3] = mk_tok(KIND_END, pos1, stop_after(pos1), '0, 1'b0, file_id);
    pres[3] = eos;
    for (int k = 0; k < 4; k++) begin
      if (pres[k] && (n_tok != 2'd3)) begin
        toks[n_tok] = cand[k];
        n_tok = n_tok + 2'd1;
      end
    end
    for (int i = 0; i < TOK_SLOTS; i++) begin
      toks[i].last_of_run = ((2'(i) + 2'd1) == n_tok);
    end
  end

  // Items that give no token never wait on the output buffer.
  assign proc = in_vld_r && ((n_tok == 2'd0) || buf_free);
  assign load_ctl.load = proc && (n_tok != 2'd0);
  assign load_ctl.count = n_tok;
  assign in_if.ready = !in_vld_r || proc;

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_item_r <= in_if.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      mode_r <= MODE_NONE;
      run_start_r <= '0;
      pos_r <= '0;
      acc_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        in_vld_r <= 1'b1;
      end else if (proc) begin
        in_vld_r <= 1'b0;
      end
      if (proc) begin
        mode_r <= mode_nxt;
        run_start_r <= run_start_nxt;
        pos_r <= pos_nxt;
        acc_r <= acc_nxt;
        ovf_r <= ovf_nxt;
      end
    end
  end
endmodule
`default_nettype wire

FILE: hdl/etl_obuf.sv
`default_nettype none
module etl_obuf (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire etl_pkg::load_ctl_t    load_ctl,
  input  wire etl_pkg::token_t       toks [etl_pkg::TOK_SLOTS],
  output logic                       buf_free,
  etl_out_if.source                  out_if
);
  import etl_pkg::*;

  logic [1:0] count_r;
  logic [1:0] count_nxt;
  token_t     slot_r [TOK_SLOTS];
  logic       pop;

  assign pop = out_if.valid && out_if.ready;
  // A new group may load when the buffer is empty or the last held token leaves in this cycle.
  assign buf_free = (count_r == 2'd0) || ((count_r == 2'd1) && pop);
  assign out_if.valid = (count_r != 2'd0);
  assign out_if.item = slot_r[0];

  always_comb begin
    count_nxt = count_r;
    if (load_ctl.load) begin
      count_nxt = load_ctl.count;
    end else if (pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ctl.load) begin
      for (int i = 0; i < TOK_SLOTS; i++) begin
        slot_r[i] <= toks[i];
      end
    end else if (pop) begin
      for (int i = 0; i < TOK_SLOTS - 1; i++) begin
        slot_r[i] <= slot_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end
endmodule
`default_nettype wire
